// File: design/xbmg_pkg.sv
// Shared constants, types and helpers for the xorshift Box-Muller noise generator.
// Used by the front, queue, back and top-level modules; no dependencies.
package xbmg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int M_W       = 53;
  localparam int SAMPLE_W  = 21;
  localparam int RND_SH    = 54 - FRAC_BITS;

  localparam logic [63:0] DEFAULT_STATE = 64'h12345678abcdef01;
  localparam logic [26:0] TWO_LN2_Q26   = 27'd93032640;
  localparam logic [32:0] TWO_PI_Q30    = 33'd6746518852;
  localparam logic [30:0] Q30_ONE       = 31'h40000000;
  localparam logic [63:0] RND_HALF      = 64'd1 << (53 - FRAC_BITS);
  localparam logic [63:0] OUT_LIM       = 64'd1 << (SAMPLE_W - 1);

  typedef struct packed {
    logic [M_W-1:0] m1;
    logic [M_W-1:0] m2;
  } xbmg_draw_t;

  function automatic logic [63:0] xs_step(input logic [63:0] s);
    logic [63:0] a;
    logic [63:0] b;
    a = s ^ (s << 13);
    b = a ^ (a >> 7);
    return b ^ (b << 17);
  endfunction

  // Horner divisors: cosine series, then sine series
  function automatic logic [6:0] h_div(input logic sin_sel, input logic [2:0] idx);
    logic [6:0] d;
    d = 7'd2;
    if (!sin_sel) begin
      case (idx)
        3'd0:    d = 7'd90;
        3'd1:    d = 7'd56;
        3'd2:    d = 7'd30;
        3'd3:    d = 7'd12;
        default: d = 7'd2;
      endcase
    end else begin
      case (idx)
        3'd0:    d = 7'd110;
        3'd1:    d = 7'd72;
        3'd2:    d = 7'd42;
        3'd3:    d = 7'd20;
        default: d = 7'd6;
      endcase
    end
    return d;
  endfunction

  // floor(2^32 / divisor), paired with h_div
  function automatic logic [31:0] h_recip(input logic sin_sel, input logic [2:0] idx);
    logic [31:0] m;
    m = 32'd2147483648;
    if (!sin_sel) begin
      case (idx)
        3'd0:    m = 32'd47721858;
        3'd1:    m = 32'd76695844;
        3'd2:    m = 32'd143165576;
        3'd3:    m = 32'd357913941;
        default: m = 32'd2147483648;
      endcase
    end else begin
      case (idx)
        3'd0:    m = 32'd39045157;
        3'd1:    m = 32'd59652323;
        3'd2:    m = 32'd102261126;
        3'd3:    m = 32'd214748364;
        default: m = 32'd715827882;
      endcase
    end
    return m;
  endfunction

endpackage

// File: design/xbmg_front.sv
// Request front end: holds the xorshift state, applies restart, draws the two uniforms.
// Depends on xbmg_pkg.
module xbmg_front import xbmg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic             in_restart,
  input  logic [63:0]      seed,
  output logic             q_push,
  output xbmg_draw_t       q_data,
  input  logic             q_full
);

  typedef enum logic [1:0] {S_IDLE, S_DRAW1, S_DRAW2} fstate_t;

  fstate_t          state_r, state_nxt;
  logic [63:0]      gen_r, gen_nxt;
  logic [M_W-1:0]   m1_r, m1_nxt;
  logic [63:0]      s_step;

  assign s_step = xs_step(gen_r);
  assign full   = (state_r != S_IDLE);
  assign q_push = (state_r == S_DRAW2) && !q_full;
  assign q_data = '{m1: m1_r, m2: s_step[63:11]};

  always_comb begin
    state_nxt = state_r;
    gen_nxt   = gen_r;
    m1_nxt    = m1_r;
    unique case (state_r)
      S_IDLE: begin
        if (push) begin
          if (in_restart) gen_nxt = (seed == '0) ? DEFAULT_STATE : seed;
          state_nxt = S_DRAW1;
        end
      end
      S_DRAW1: begin
        // redraw while the first uniform is zero
        gen_nxt = s_step;
        m1_nxt  = s_step[63:11];
        if (s_step[63:11] != '0) state_nxt = S_DRAW2;
      end
      S_DRAW2: begin
        if (!q_full) begin
          gen_nxt   = s_step;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gen_r   <= DEFAULT_STATE;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
    end
    m1_r <= m1_nxt;
  end

  a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n) gen_r != '0)
    else $error("generator state reached zero");

  a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_data.m1 != '0))
    else $error("zero first draw forwarded");

endmodule

// File: design/xbmg_queue.sv
// Two-entry queue of drawn uniform pairs between the front end and the back end.
// Depends on xbmg_pkg.
module xbmg_queue import xbmg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_push,
  input  xbmg_draw_t  q_wdata,
  output logic        q_full,
  input  logic        q_pop,
  output logic        q_empty,
  output xbmg_draw_t  q_rdata
);

  xbmg_draw_t  ent_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign q_rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (q_push && !q_full) wp_r <= ~wp_r;
      if (q_pop && !q_empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(q_push && !q_full) - 2'(q_pop && !q_empty);
    end
    if (q_push && !q_full) ent_r[wp_r] <= q_wdata;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");

endmodule

// File: design/xbmg_back.sv
// Back end: log, square root and cosine/sine by iterative steps on one shared multiplier.
// Depends on xbmg_pkg; holds the single-entry result register.
module xbmg_back import xbmg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  xbmg_draw_t                 q_rdata,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] out_sample
);

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_LOG, S_VLO, S_VHI, S_SQRT, S_XLO, S_XHI, S_X2,
    S_HMUL, S_HDIV, S_HCOR, S_SINM, S_OMUL
  } bstate_t;

  bstate_t               state_r;
  logic [M_W-1:0]        m1_r;
  logic [5:0]            e_r;
  logic [30:0]           f_r;
  logic [29:0]           l_r;
  logic [4:0]            cnt_r;
  logic [63:0]           acc64_r;
  logic [54:0]           w_r, res_r, bit_r;
  logic [29:0]           k_r, x_r, x2_r, y_r;
  logic [28:0]           qt_r;
  logic [30:0]           acc_r;
  logic                  cos_r, neg_r;
  logic                  ov_r;
  logic signed [SAMPLE_W-1:0] out_r;

  logic [31:0]           op_a, op_b;
  logic [63:0]           mul_p;
  logic [35:0]           t_val;
  logic [63:0]           v_sum;
  logic [55:0]           rb;
  logic [31:0]           p_val;
  logic [30:0]           r_fold;
  logic [31:0]           sq;
  logic [6:0]            dv;
  logic [35:0]           rem;
  logic [28:0]           qq;
  logic [63:0]           rnd;
  logic [63:0]           mag_s;
  logic signed [SAMPLE_W-1:0] smp;
  logic                  out_free;
  logic                  out_load;

  assign mul_p    = 64'(op_a) * 64'(op_b);
  assign t_val    = {6'd53 - e_r, 30'd0} - {6'd0, l_r};
  assign v_sum    = acc64_r + (mul_p << 18);
  assign rb       = 56'(res_r) + 56'(bit_r);
  assign p_val    = q_rdata.m2[52:21];
  assign r_fold   = (p_val[29:0] <= 30'h20000000) ? {1'b0, p_val[29:0]}
                                                  : 31'h40000000 - {1'b0, p_val[29:0]};
  assign sq       = mul_p[61:30];
  assign dv       = h_div(!cos_r, cnt_r[2:0]);
  assign rem      = {6'd0, y_r} - 36'(qt_r) * 36'(dv);
  assign qq       = (rem >= 36'(dv)) ? qt_r + 29'd1 : qt_r;
  assign rnd      = (mul_p + RND_HALF) >> RND_SH;
  assign mag_s    = (rnd > OUT_LIM) ? OUT_LIM : rnd;
  assign out_free = !ov_r || pop;
  assign out_load = (state_r == S_OMUL) && out_free;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign empty    = !ov_r;
  assign out_sample = out_r;

  always_comb begin
    if (neg_r) smp = SAMPLE_W'(-mag_s);
    else if (mag_s == OUT_LIM) smp = SAMPLE_W'(OUT_LIM - 64'd1);
    else smp = SAMPLE_W'(mag_s);
  end

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_LOG:  begin op_a = 32'(f_r);          op_b = 32'(f_r); end
      S_VLO:  begin op_a = 32'(t_val[17:0]);  op_b = 32'(TWO_LN2_Q26); end
      S_VHI:  begin op_a = 32'(t_val[35:18]); op_b = 32'(TWO_LN2_Q26); end
      S_XLO:  begin op_a = 32'(k_r);          op_b = 32'(TWO_PI_Q30[15:0]); end
      S_XHI:  begin op_a = 32'(k_r);          op_b = 32'(TWO_PI_Q30[32:16]); end
      S_X2:   begin op_a = 32'(acc64_r[61:32]); op_b = 32'(acc64_r[61:32]); end
      S_HMUL: begin op_a = 32'(x2_r);         op_b = 32'(acc_r); end
      S_HDIV: begin op_a = 32'(y_r);          op_b = h_recip(!cos_r, cnt_r[2:0]); end
      S_SINM: begin op_a = 32'(x_r);          op_b = 32'(acc_r); end
      S_OMUL: begin op_a = 32'(res_r[27:0]);  op_b = 32'(acc_r); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (pop && ov_r && !out_load) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            m1_r    <= q_rdata.m1;
            e_r     <= 6'd52;
            k_r     <= r_fold[29:0];
            cos_r   <= (p_val[29:0] <= 30'h20000000) == !p_val[30];
            neg_r   <= (p_val[31:30] == 2'd1) || (p_val[31:30] == 2'd2);
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (m1_r[52]) begin
            f_r     <= m1_r[52:22];
            l_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_LOG;
          end else begin
            m1_r <= m1_r << 1;
            e_r  <= e_r - 6'd1;
          end
        end
        S_LOG: begin
          // square and renormalise; one fraction bit of log2 per pass
          f_r   <= sq[31] ? sq[31:1] : sq[30:0];
          l_r   <= {l_r[28:0], sq[31]};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd29) state_r <= S_VLO;
        end
        S_VLO: begin
          acc64_r <= mul_p;
          state_r <= S_VHI;
        end
        S_VHI: begin
          w_r     <= {v_sum[62:26], 18'd0};
          res_r   <= '0;
          bit_r   <= 55'd1 << 54;
          cnt_r   <= '0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (56'(w_r) >= rb) begin
            w_r   <= 55'(56'(w_r) - rb);
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd27) state_r <= S_XLO;
        end
        S_XLO: begin
          acc64_r <= mul_p;
          state_r <= S_XHI;
        end
        S_XHI: begin
          acc64_r <= acc64_r + (mul_p << 16);
          state_r <= S_X2;
        end
        S_X2: begin
          x_r     <= acc64_r[61:32];
          x2_r    <= mul_p[59:30];
          acc_r   <= Q30_ONE;
          cnt_r   <= '0;
          state_r <= S_HMUL;
        end
        S_HMUL: begin
          y_r     <= mul_p[59:30];
          state_r <= S_HDIV;
        end
        S_HDIV: begin
          qt_r    <= mul_p[60:32];
          state_r <= S_HCOR;
        end
        S_HCOR: begin
          // reciprocal estimate is at most one low; fix it with the remainder
          acc_r <= Q30_ONE - {2'd0, qq};
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd4) state_r <= cos_r ? S_OMUL : S_SINM;
          else state_r <= S_HMUL;
        end
        S_SINM: begin
          acc_r   <= mul_p[60:30];
          state_r <= S_OMUL;
        end
        S_OMUL: begin
          if (out_free) begin
            out_r   <= smp;
            ov_r    <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOG) |-> f_r[30])
    else $error("log mantissa left [1,2)");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_NORM))
    else $error("queued pair taken without starting");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !pop) |=> ($stable(out_r) && ov_r))
    else $error("waiting result overwritten");

endmodule

// File: design/xorshift_box_muller_gaussian_core.sv
// Gaussian noise core: each sample runs through the back end's 30-pass log loop,
// 28-pass square root and five Horner steps (multiply, reciprocal multiply, correction)
// on one shared multiplier, plus a multiply by x for the sine and one normalising shift
// per leading zero of the first uniform. The back end starts a new pair only when idle;
// the front end draws the next pair while the back works.
// Synchronous active-low reset: seed clears to zero, generator state loads the default
// start value, queue and result register empty.
module xorshift_box_muller_gaussian_core import xbmg_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_restart,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  logic [63:0] seed_r;
  logic        q_push, q_full, q_pop, q_empty;
  xbmg_draw_t  q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (psel && penable && pwrite && (paddr[3] == 1'b0)) begin
      seed_r <= pwdata;
    end
  end

  xbmg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_restart (in_restart),
    .seed       (seed_r),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  xbmg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_rdata (q_rdata)
  );

  xbmg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_sample (out_sample)
  );

endmodule

// File: test/tb.sv
// Testbench for xorshift_box_muller_gaussian_core: random and directed requests, APB seed writes.
// Uses xbmg_pkg from the design; predicts every sample with its own fixed-point model.
`timescale 1ns / 1ps

module tb;
  import xbmg_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_restart = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  localparam logic [3:0] ADDR_SEED = 4'd0;
  localparam logic [3:0] ADDR_UNUSED = 4'd8;

  xorshift_box_muller_gaussian_core DUT (.*);

  always #5 clk = ~clk;

  bit restart_pending[$];
  logic [SAMPLE_W-1:0] sample_expected[$];
  logic [63:0] seed_copy = '0;
  logic [63:0] xs_copy = DEFAULT_STATE;
  int errors = 0;
  bit quiet = 1'b0;
  int hold_req = 0;

  function automatic logic [63:0] next_uniform();
    logic [63:0] s;
    s = xs_copy;
    s = s ^ (s << 13);
    s = s ^ (s >> 7);
    s = s ^ (s << 17);
    xs_copy = s;
    return s >> 11;
  endfunction

  function automatic logic [63:0] neg_two_ln(input logic [63:0] m);
    int e;
    logic [63:0] f;
    logic [63:0] l;
    logic [63:0] t;
    e = 52;
    l = '0;
    while (e > 0 && m[e] == 1'b0) e--;
    f = (e >= 30) ? (m >> (e - 30)) : (m << (30 - e));
    for (int i = 1; i <= 30; i++) begin
      f = (f * f) >> 30;
      if (f >= (64'd2 << 30)) begin
        f = f >> 1;
        l = l | (64'd1 << (30 - i));
      end
    end
    t = (64'(53 - e) << 30) - l;
    return (t * 64'd93032640) >> 26;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] w);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > w) b = b >> 2;
    while (b != 0) begin
      if (w >= res + b) begin
        w = w - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Horner series in Q30; odd selects the sine divisors and the final multiply by x
  function automatic logic [63:0] trig_q30(input logic [63:0] x, input bit odd);
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] d;
    x2 = (x * x) >> 30;
    acc = 64'd1 << 30;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: d = odd ? 64'd110 : 64'd90;
        1: d = odd ? 64'd72 : 64'd56;
        2: d = odd ? 64'd42 : 64'd30;
        3: d = odd ? 64'd20 : 64'd12;
        default: d = odd ? 64'd6 : 64'd2;
      endcase
      acc = (64'd1 << 30) - ((x2 * acc) >> 30) / d;
    end
    return odd ? ((x * acc) >> 30) : acc;
  endfunction

  function automatic logic [SAMPLE_W-1:0] gauss_sample(input bit restart);
    logic [63:0] m1;
    logic [63:0] m2;
    logic [63:0] radius;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] ca;
    logic [63:0] sa;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [1:0] q;
    bit neg;
    longint val;
    if (restart) xs_copy = (seed_copy == 0) ? DEFAULT_STATE : seed_copy;
    do m1 = next_uniform(); while (m1 == 0);
    m2 = next_uniform();
    radius = int_sqrt(neg_two_ln(m1) << 18);
    p = m2 >> 21;
    q = p[31:30];
    r = p & ((64'd1 << 30) - 1);
    if (r <= (64'd1 << 29)) begin
      x = (r * 64'd6746518852) >> 32;
      ca = trig_q30(x, 1'b0);
      sa = trig_q30(x, 1'b1);
    end else begin
      x = (((64'd1 << 30) - r) * 64'd6746518852) >> 32;
      ca = trig_q30(x, 1'b1);
      sa = trig_q30(x, 1'b0);
    end
    mag = q[0] ? sa : ca;
    neg = (q == 2'd1) || (q == 2'd2);
    prod = radius * mag;
    prod = (prod + (64'd1 << (53 - FRAC_BITS))) >> (54 - FRAC_BITS);
    if (prod > 64'd1048576) prod = 64'd1048576;
    val = neg ? -longint'(prod) : longint'(prod);
    if (val > 1048575) val = 1048575;
    if (val < -1048576) val = -1048576;
    return val[SAMPLE_W-1:0];
  endfunction

  task automatic add_request(input bit restart);
    restart_pending.insert(restart_pending.size(), restart);
  endtask

  // Request side
  int push_gap = 0;
  always @(posedge clk) begin
    bit nxt_push;
    bit nxt_rst;
    nxt_push = push;
    nxt_rst = in_restart;
    if (rst_n) begin
      if (push && !full) begin
        sample_expected.insert(sample_expected.size(), gauss_sample(in_restart));
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (push_gap > 0) begin
          push_gap--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          push_gap = $urandom_range(1, 8);
        end else if (restart_pending.size() > 0) begin
          nxt_push = 1'b1;
          nxt_rst = restart_pending.pop_front();
        end
      end
    end
    push <= nxt_push;
    in_restart <= nxt_rst;
  end

  // Result side
  int pop_gap = 0;
  always @(posedge clk) begin
    bit nxt_pop;
    logic [SAMPLE_W-1:0] want;
    nxt_pop = 1'b0;
    if (rst_n) begin
      if (pop && !empty) begin
        if (sample_expected.size() == 0) begin
          $error("sample: no request outstanding, actual %0d", out_sample);
          errors++;
        end else begin
          want = sample_expected.pop_front();
          if (out_sample !== want) begin
            $error("sample: expected %0d actual %0d", $signed(want), out_sample);
            errors++;
          end
        end
      end
      if (hold_req > 0) begin
        hold_req--;
      end else if (pop_gap > 0) begin
        pop_gap--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        pop_gap = $urandom_range(1, 8);
      end else begin
        nxt_pop = 1'b1;
      end
    end
    pop <= nxt_pop;
  end

  task automatic cfg_write(input logic [3:0] addr, input logic [63:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_SEED) seed_copy = data;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (restart_pending.size() > 0 || push || sample_expected.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    repeat (n) add_request($urandom_range(0, 9) == 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // default start value straight from reset, then a restart with seed zero
    add_request(1'b0);
    add_request(1'b0);
    add_request(1'b1);
    add_request(1'b0);
    drain();
    cfg_write(ADDR_SEED, '1);
    add_request(1'b1);
    add_request(1'b0);
    add_request(1'b1);
    drain();
    cfg_write(ADDR_SEED, 64'd1);
    add_request(1'b1);
    add_request(1'b0);
    add_request(1'b0);
    drain();
    // unused register: seed must survive
    cfg_write(ADDR_UNUSED, 64'hdead_beef_0000_0001);
    add_request(1'b1);
    add_request(1'b0);
    drain();
    cfg_write(ADDR_SEED, 64'h8000_0000_0000_0000);
    add_request(1'b1);
    queue_random(120);
    drain();
    cfg_write(ADDR_SEED, {$urandom, $urandom});
    add_request(1'b1);
    hold_req = 600;   // hold results back until the core backs up
    queue_random(120);
    drain();
    cfg_write(ADDR_SEED, '0);
    queue_random(120);
    drain();
    cfg_write(ADDR_SEED, {$urandom, $urandom});
    queue_random(60);
    drain();
    quiet = 1'b1;
    queue_random(80);
    drain();
    repeat (200) @(posedge clk);
    if (sample_expected.size() != 0) begin
      $error("sample: %0d results never arrived", sample_expected.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
